// ----- hw/rtl/compare_split_sort_unit_defines.svh -----
// assertion macros for the compare-split sort unit
`ifndef COMPARE_SPLIT_SORT_UNIT_DEFINES_SVH
`define COMPARE_SPLIT_SORT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("css assertion failed");
`define CSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("css assertion failed");
`else
`define CSS_ASSERT_IMP(lbl, ante, cons)
`define CSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/css_pkg.sv -----
package css_pkg;

    localparam int MAX_KEYS = 64;
    localparam int ADDR_W   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int KEY_W    = 32;

    localparam logic CFG_KEEP_LOW  = 1'b0;
    localparam logic CFG_KEY_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_MARK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                    used;
        logic signed [KEY_W-1:0] key;
    } word_t;

    typedef struct packed {
        logic                    found;
        logic                    src;
        logic [ADDR_W-1:0]       addr;
        logic signed [KEY_W-1:0] key;
    } best_t;

endpackage

// ----- hw/rtl/css_in_if.sv -----
interface css_in_if
    import css_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key;
    logic                    from_partner;

    modport source (output valid, output key, output from_partner, input ready);
    modport sink (input valid, input key, input from_partner, output ready);
endinterface

// ----- hw/rtl/css_out_if.sv -----
interface css_out_if
    import css_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] kept_key;
    logic                    last;

    modport source (output valid, output kept_key, output last, input ready);
    modport sink (input valid, input kept_key, input last, output ready);
endinterface

// ----- hw/rtl/css_ram.sv -----
module css_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hw/rtl/css_pick.sv -----
module css_pick
    import css_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              sample,
    input  logic [ADDR_W-1:0] addr,
    input  word_t             l_word,
    input  word_t             p_word,
    output best_t             best
);
    best_t best_reg;
    best_t best_next;
    logic                    take_local;
    logic                    cand_ok;
    logic signed [KEY_W-1:0] cand_key;

    always_comb
    begin
        take_local = !l_word.used && (p_word.used || (l_word.key <= p_word.key));
        cand_ok    = !l_word.used || !p_word.used;
        cand_key   = take_local ? l_word.key : p_word.key;
        best_next  = best_reg;
        if (clear)
        begin
            best_next.found = 1'b0;
        end
        else if (sample && cand_ok && (!best_reg.found || (cand_key < best_reg.key)))
        begin
            best_next.found = 1'b1;
            best_next.src   = !take_local;
            best_next.addr  = addr;
            best_next.key   = cand_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;
endmodule

// ----- hw/rtl/compare_split_sort_unit.sv -----
// channel  dir  payload                 handshake
// in_ch    in   key, from_partner       valid / ready
// out_ch   out  kept_key, last          valid / ready
// cfg      in   cfg_index, cfg_data     cfg_we
// a key is taken on valid and ready; ready stays low from the completing item until the last result is taken
// each pick scans both stores: n reads, a drain of the read pipeline, then a write to mark the entry
// each kept key then holds the output while ready is low
// keep_low clear first drops n keys by the same scan, doubling the picks
// a run takes one or two passes of n picks plus output stalls, n the clamped key_count
// reset clears the fill counts and the controller; store contents need no clearing
`include "compare_split_sort_unit_defines.svh"

module compare_split_sort_unit
    import css_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    css_in_if.sink     in_ch,
    css_out_if.source  out_ch
);
    state_t state_reg, state_next;
    logic              keep_low_reg;
    logic [6:0]        key_count_reg;
    logic [CNT_W-1:0]  local_fill_reg, local_fill_next;
    logic [CNT_W-1:0]  partner_fill_reg, partner_fill_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [CNT_W-1:0]  pick_reg, pick_next;
    logic              emit_reg, emit_next;
    logic signed [KEY_W-1:0] out_key_reg, out_key_next;
    logic              out_last_reg, out_last_next;

    logic [CNT_W-1:0]  n;
    logic              clear;
    logic              l_we, p_we, rd_en;
    logic [ADDR_W-1:0] l_waddr, p_waddr;
    word_t             wword, l_rword, p_rword;
    best_t             best;
    logic              in_acc;

    always_comb
    begin
        if (key_count_reg == 7'd0)
        begin
            n = CNT_W'(1);
        end
        else if (int'(key_count_reg) > MAX_KEYS)
        begin
            n = CNT_W'(MAX_KEYS);
        end
        else
        begin
            n = CNT_W'(key_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_low_reg  <= 1'b1;
            key_count_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEEP_LOW:  keep_low_reg  <= cfg_data[0];
                CFG_KEY_COUNT: key_count_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign in_ch.ready     = (state_reg == ST_LOAD);
    assign in_acc          = in_ch.valid && in_ch.ready;
    assign out_ch.valid    = (state_reg == ST_OUT);
    assign out_ch.kept_key = out_key_reg;
    assign out_ch.last     = out_last_reg;

    always_comb
    begin
        state_next        = state_reg;
        local_fill_next   = local_fill_reg;
        partner_fill_next = partner_fill_reg;
        issue_next        = issue_reg;
        rd_valid_next     = 1'b0;
        pick_next         = pick_reg;
        emit_next         = emit_reg;
        out_key_next      = out_key_reg;
        out_last_next     = out_last_reg;
        clear             = 1'b0;
        l_we              = 1'b0;
        p_we              = 1'b0;
        rd_en             = 1'b0;
        l_waddr           = local_fill_reg[ADDR_W-1:0];
        p_waddr           = partner_fill_reg[ADDR_W-1:0];
        wword.used        = 1'b0;
        wword.key         = in_ch.key;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (in_ch.from_partner)
                    begin
                        if (partner_fill_reg < n)
                        begin
                            p_we              = 1'b1;
                            partner_fill_next = partner_fill_reg + CNT_W'(1);
                        end
                    end
                    else if (local_fill_reg < n)
                    begin
                        l_we            = 1'b1;
                        local_fill_next = local_fill_reg + CNT_W'(1);
                    end
                    if ((local_fill_next >= n) && (partner_fill_next >= n))
                    begin
                        local_fill_next   = '0;
                        partner_fill_next = '0;
                        state_next        = ST_SCAN;
                        clear             = 1'b1;
                        issue_next        = '0;
                        pick_next         = '0;
                        emit_next         = keep_low_reg;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < n)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    issue_next    = issue_reg + CNT_W'(1);
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                wword.used = 1'b1;
                wword.key  = best.key;
                l_waddr    = best.addr;
                p_waddr    = best.addr;
                l_we       = !best.src;
                p_we       = best.src;
                if (emit_reg)
                begin
                    out_key_next  = best.key;
                    out_last_next = (pick_reg == n - CNT_W'(1));
                    state_next    = ST_OUT;
                end
                else
                begin
                    if (pick_reg == n - CNT_W'(1))
                    begin
                        emit_next = 1'b1;
                        pick_next = '0;
                    end
                    else
                    begin
                        pick_next = pick_reg + CNT_W'(1);
                    end
                    state_next = ST_SCAN;
                    clear      = 1'b1;
                    issue_next = '0;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    if (out_last_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        pick_next  = pick_reg + CNT_W'(1);
                        state_next = ST_SCAN;
                        clear      = 1'b1;
                        issue_next = '0;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            local_fill_reg   <= '0;
            partner_fill_reg <= '0;
            issue_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            pick_reg         <= '0;
            emit_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            local_fill_reg   <= local_fill_next;
            partner_fill_reg <= partner_fill_next;
            issue_reg        <= issue_next;
            rd_valid_reg     <= rd_valid_next;
            pick_reg         <= pick_next;
            emit_reg         <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= issue_reg[ADDR_W-1:0];
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
    end

    css_ram #(
        .WIDTH ($bits(word_t)),
        .DEPTH (MAX_KEYS)
    ) u_local_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (wword),
        .re    (rd_en),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (l_rword)
    );

    css_ram #(
        .WIDTH ($bits(word_t)),
        .DEPTH (MAX_KEYS)
    ) u_partner_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (wword),
        .re    (rd_en),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (p_rword)
    );

    css_pick u_pick (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (clear),
        .sample (rd_valid_reg),
        .addr   (rd_addr_reg),
        .l_word (l_rword),
        .p_word (p_rword),
        .best   (best)
    );

    `CSS_ASSERT_IMP(a_one_write, 1'b1, !(l_we && p_we))
    `CSS_ASSERT_IMP(a_mark_found, state_reg == ST_MARK, best.found)
    `CSS_ASSERT_IMP(a_no_load_busy, in_ch.ready, !out_ch.valid && !rd_valid_reg)
    `CSS_ASSERT_NEXT(a_last_done, out_ch.valid && out_ch.ready && out_ch.last,
                     in_ch.ready && (local_fill_reg == '0) && (partner_fill_reg == '0))
endmodule
